// ----- src/text_tokenizer_stream_assert.svh -----
// Assertion helpers for the tokenizer; clock clk, synchronous reset rst_n.
`ifndef TEXT_TOKENIZER_STREAM_ASSERT_SVH
`define TEXT_TOKENIZER_STREAM_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define TTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer check failed: same-cycle rule");

// Next-cycle implication, masked during reset.
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer check failed: next-cycle rule");

`endif

// ----- src/tts_pkg.sv -----
package tts_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [2:0]  token_kind;
    logic [7:0]  char_value;
    logic [1:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last;
  } out_item_t;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_IDENT = 4'd1,
    M_NINT  = 4'd2,
    M_NFRAC = 4'd3,
    M_NE    = 4'd4,
    M_NEM   = 4'd5,
    M_NEXP  = 4'd6,
    M_STR   = 4'd7,
    M_SESC  = 4'd8,
    M_SLASH = 4'd9,
    M_LCOM  = 4'd10,
    M_BCOM  = 4'd11,
    M_BSTAR = 4'd12,
    M_ERR   = 4'd13
  } scan_mode_t;

  typedef enum logic [1:0] {
    EV_CHAR = 2'd0,
    EV_END  = 2'd1,
    EV_ERR  = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    TK_ID  = 3'd0,
    TK_NUM = 3'd1,
    TK_STR = 3'd2,
    TK_OP  = 3'd3,
    TK_NL  = 3'd4
  } token_kind_t;

  localparam logic [1:0] ERR_NUM_CHAR   = 2'd0;
  localparam logic [1:0] ERR_EXPONENT   = 2'd1;
  localparam logic [1:0] ERR_ESCAPE     = 2'd2;
  localparam logic [1:0] ERR_UNTERM_STR = 2'd3;
  localparam logic [1:0] ERR_NONE       = 2'd0;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_E      = 8'h65;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_EVENTS  = 4;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] token_kind;
    logic [7:0] char_value;
    logic [1:0] error_code;
  } tts_event_t;

  // All events caused by one input item; they share the counters
  typedef struct packed {
    tts_event_t [MAX_EVENTS-1:0] ev;
    logic [2:0]                  count;
    logic [15:0]                 line_number;
    logic [15:0]                 column_number;
  } bundle_t;

  function automatic tts_event_t mk_ev(event_kind_t ek, token_kind_t tk,
                                       logic [7:0] ch, logic [1:0] code);
    tts_event_t e;
    e.event_kind = ek;
    e.token_kind = tk;
    e.char_value = ch;
    e.error_code = code;
    return e;
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // Escape decode: bit 8 set when the escape is known
  function automatic logic [8:0] esc_decode(logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      CH_BSLASH, CH_SLASH, CH_QUOTE: r = {1'b1, b};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'h000;
    endcase
    return r;
  endfunction

endpackage

// ----- src/tts_front.sv -----
module tts_front #(
  parameter int COUNTER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  tts_pkg::in_item_t item,
  output logic              push,
  output tts_pkg::bundle_t  bundle
);

  tts_pkg::scan_mode_t     mode_r, mode_nxt;
  logic [COUNTER_BITS-1:0] line_r, line_nxt;
  logic [COUNTER_BITS-1:0] col_r, col_nxt;
  logic [COUNTER_BITS-1:0] line_cnt, col_cnt;
  logic [31:0]             line_wide, col_wide;
  logic [7:0]              b;
  logic                    eos;
  logic                    restart;
  logic [2:0]              n;
  logic [8:0]              esc;
  tts_pkg::tts_event_t [tts_pkg::MAX_EVENTS-1:0] ev;

  assign b   = item.byte_value;
  assign eos = item.action || (b == tts_pkg::CH_NUL);
  assign esc = tts_pkg::esc_decode(b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tts_pkg::M_IDLE;
      line_r <= COUNTER_BITS'(1);
      col_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

  // Counters as seen by this item's events
  always_comb begin
    line_cnt = line_r;
    col_cnt  = col_r;
    if (!eos) begin
      if (b == tts_pkg::CH_NL) begin
        if (line_r != '1) line_cnt = line_r + COUNTER_BITS'(1);
        col_cnt = '0;
      end else if (col_r != '1) begin
        col_cnt = col_r + COUNTER_BITS'(1);
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    restart  = 1'b0;
    n        = 3'd0;
    ev       = '0;
    if (accept) begin
      if (eos) begin
        unique case (mode_r)
          tts_pkg::M_IDENT: begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_ID, 8'h00,
                                        tts_pkg::ERR_NONE);
            n = n + 3'd1;
          end
          tts_pkg::M_NINT, tts_pkg::M_NFRAC, tts_pkg::M_NEXP: begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_NUM, 8'h00,
                                        tts_pkg::ERR_NONE);
            n = n + 3'd1;
          end
          tts_pkg::M_NE, tts_pkg::M_NEM: begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_ERR, tts_pkg::TK_NUM, 8'h00,
                                        tts_pkg::ERR_EXPONENT);
            n = n + 3'd1;
          end
          tts_pkg::M_STR, tts_pkg::M_SESC: begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_ERR, tts_pkg::TK_STR, 8'h00,
                                        tts_pkg::ERR_UNTERM_STR);
            n = n + 3'd1;
          end
          tts_pkg::M_SLASH: begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_OP,
                                        tts_pkg::CH_SLASH, tts_pkg::ERR_NONE);
            n = n + 3'd1;
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_OP, 8'h00,
                                        tts_pkg::ERR_NONE);
            n = n + 3'd1;
          end
          default: ;
        endcase
        mode_nxt = tts_pkg::M_IDLE;
        line_nxt = COUNTER_BITS'(1);
        col_nxt  = '0;
      end else begin
        line_nxt = line_cnt;
        col_nxt  = col_cnt;
        unique case (mode_r)
          tts_pkg::M_IDENT: begin
            if (b == tts_pkg::CH_UNDER || tts_pkg::is_alpha(b) || tts_pkg::is_digit(b)) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_ID, b,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
            end else begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_ID, 8'h00,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              restart = 1'b1;
            end
          end
          tts_pkg::M_NINT, tts_pkg::M_NFRAC: begin
            if (b == tts_pkg::CH_DOT) begin
              if (mode_r == tts_pkg::M_NFRAC) begin
                ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_ERR, tts_pkg::TK_NUM, b,
                                            tts_pkg::ERR_NUM_CHAR);
                n = n + 3'd1;
                mode_nxt = tts_pkg::M_ERR;
              end else begin
                ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_NUM, b,
                                            tts_pkg::ERR_NONE);
                n = n + 3'd1;
                mode_nxt = tts_pkg::M_NFRAC;
              end
            end else if (tts_pkg::is_digit(b)) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
            end else if (b == tts_pkg::CH_E) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_NE;
            end else begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_NUM, 8'h00,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              restart = 1'b1;
            end
          end
          tts_pkg::M_NE: begin
            if (b == tts_pkg::CH_MINUS) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_NEM;
            end else if (tts_pkg::is_digit(b)) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_NEXP;
            end else begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_ERR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_EXPONENT);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_ERR;
            end
          end
          tts_pkg::M_NEM: begin
            if (tts_pkg::is_digit(b)) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_NEXP;
            end else begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_ERR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_EXPONENT);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_ERR;
            end
          end
          tts_pkg::M_NEXP: begin
            if (tts_pkg::is_digit(b)) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
            end else if (b == tts_pkg::CH_DOT || b == tts_pkg::CH_E) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_ERR, tts_pkg::TK_NUM, b,
                                          tts_pkg::ERR_NUM_CHAR);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_ERR;
            end else begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_NUM, 8'h00,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              restart = 1'b1;
            end
          end
          tts_pkg::M_STR: begin
            if (b == tts_pkg::CH_BSLASH) begin
              mode_nxt = tts_pkg::M_SESC;
            end else if (b == tts_pkg::CH_QUOTE) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_STR, 8'h00,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_IDLE;
            end else begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_STR, b,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
            end
          end
          tts_pkg::M_SESC: begin
            if (esc[8]) begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_STR, esc[7:0],
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_STR;
            end else begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_ERR, tts_pkg::TK_STR, b,
                                          tts_pkg::ERR_ESCAPE);
              n = n + 3'd1;
              mode_nxt = tts_pkg::M_ERR;
            end
          end
          tts_pkg::M_SLASH: begin
            if (b == tts_pkg::CH_STAR) begin
              mode_nxt = tts_pkg::M_BCOM;
            end else if (b == tts_pkg::CH_SLASH) begin
              mode_nxt = tts_pkg::M_LCOM;
            end else begin
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_OP,
                                          tts_pkg::CH_SLASH, tts_pkg::ERR_NONE);
              n = n + 3'd1;
              ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_OP, 8'h00,
                                          tts_pkg::ERR_NONE);
              n = n + 3'd1;
              restart = 1'b1;
            end
          end
          tts_pkg::M_LCOM: begin
            if (b == tts_pkg::CH_NL) mode_nxt = tts_pkg::M_IDLE;
          end
          tts_pkg::M_BCOM: begin
            if (b == tts_pkg::CH_STAR) mode_nxt = tts_pkg::M_BSTAR;
          end
          tts_pkg::M_BSTAR: begin
            if (b == tts_pkg::CH_SLASH) mode_nxt = tts_pkg::M_IDLE;
            else if (b != tts_pkg::CH_STAR) mode_nxt = tts_pkg::M_BCOM;
          end
          tts_pkg::M_ERR: ;
          default: restart = 1'b1;
        endcase

        // byte handled as if between tokens
        if (restart) begin
          mode_nxt = tts_pkg::M_IDLE;
          if (b == tts_pkg::CH_SPACE || b == tts_pkg::CH_TAB || b == tts_pkg::CH_CR) begin
            mode_nxt = tts_pkg::M_IDLE;
          end else if (b == tts_pkg::CH_NL) begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_NL, 8'h00,
                                        tts_pkg::ERR_NONE);
            n = n + 3'd1;
          end else if (b == tts_pkg::CH_HASH) begin
            mode_nxt = tts_pkg::M_LCOM;
          end else if (b == tts_pkg::CH_UNDER || tts_pkg::is_alpha(b)) begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_ID, b,
                                        tts_pkg::ERR_NONE);
            n = n + 3'd1;
            mode_nxt = tts_pkg::M_IDENT;
          end else if (tts_pkg::is_digit(b)) begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_NUM, b,
                                        tts_pkg::ERR_NONE);
            n = n + 3'd1;
            mode_nxt = tts_pkg::M_NINT;
          end else if (b == tts_pkg::CH_QUOTE) begin
            mode_nxt = tts_pkg::M_STR;
          end else if (b == tts_pkg::CH_SLASH) begin
            mode_nxt = tts_pkg::M_SLASH;
          end else begin
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_CHAR, tts_pkg::TK_OP, b,
                                        tts_pkg::ERR_NONE);
            n = n + 3'd1;
            ev[n[1:0]] = tts_pkg::mk_ev(tts_pkg::EV_END, tts_pkg::TK_OP, 8'h00,
                                        tts_pkg::ERR_NONE);
            n = n + 3'd1;
          end
        end
      end
    end
  end

  // 16-bit view of the counters, zero-extended for narrow counters
  assign line_wide = 32'(line_cnt);
  assign col_wide  = 32'(col_cnt);

  assign push                 = accept && (n != 3'd0);
  assign bundle.ev            = ev;
  assign bundle.count         = n;
  assign bundle.line_number   = line_wide[15:0];
  assign bundle.column_number = col_wide[15:0];

endmodule

// ----- src/tts_queue.sv -----
module tts_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tts_pkg::bundle_t push_data,
  input  logic             pop,
  output tts_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_BITS = (tts_pkg::QUEUE_DEPTH > 1) ? $clog2(tts_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(tts_pkg::QUEUE_DEPTH + 1);

  tts_pkg::bundle_t    slot_r [tts_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_BITS'(tts_pkg::QUEUE_DEPTH));
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(tts_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_r + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(tts_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_r + PTR_BITS'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CNT_BITS'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- src/tts_back.sv -----
module tts_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tts_pkg::bundle_t   head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tts_pkg::out_item_t out_data
);

  logic [1:0]          idx_r, idx_nxt;
  logic                valid_r, valid_nxt;
  tts_pkg::out_item_t  data_r, data_nxt;
  logic                load;
  logic                is_last;
  tts_pkg::tts_event_t cur;

  assign cur     = head.ev[idx_r];
  assign is_last = ({1'b0, idx_r} == head.count - 3'd1);
  assign load    = head_valid && (!valid_r || !out_stall);
  assign pop     = load && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (valid_r && !out_stall) valid_nxt = 1'b0;
    if (load) begin
      valid_nxt              = 1'b1;
      idx_nxt                = is_last ? 2'd0 : idx_r + 2'd1;
      data_nxt.event_kind    = cur.event_kind;
      data_nxt.token_kind    = cur.token_kind;
      data_nxt.char_value    = cur.char_value;
      data_nxt.error_code    = cur.error_code;
      data_nxt.line_number   = head.line_number;
      data_nxt.column_number = head.column_number;
      data_nxt.last          = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- src/text_tokenizer_stream.sv -----
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall   tts_pkg::in_item_t (action, byte_value)
// out_     output     out_valid/out_stall tts_pkg::out_item_t (one token event)
//
// The front classifies a byte in the cycle it is accepted and queues 0 to 4 events.
// The back sends one event per cycle from a registered output stage while out_stall
// is low; each event of an item takes its own slot, and the output port sets the pace.
// Input stalls only when the two-entry event queue is full.
// Reset (rst_n low, synchronous) empties the queue and returns to line 1, column 0.
`include "text_tokenizer_stream_assert.svh"

module text_tokenizer_stream #(
  parameter int COUNTER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tts_pkg::out_item_t out_data
);

  logic             in_accept;
  logic             q_push, q_pop, q_empty, q_full;
  tts_pkg::bundle_t q_in, q_head;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  tts_front #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .push   (q_push),
    .bundle (q_in)
  );

  tts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // a bundle partly sent keeps the output stage busy in the next cycle
  `TTS_ASSERT_NEXT(a_bundle_continues, out_valid && !out_stall && !out_data.last, out_valid)
  // the back never pops an empty queue
  `TTS_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty)
  // a queued bundle always carries at least one and at most four events
  `TTS_ASSERT_NOW(a_bundle_count, q_push, q_in.count != 3'd0 && q_in.count <= 3'd4)

endmodule
